FILE: src/ipv6p_pkg.sv
`timescale 1ns / 1ps
// ipv6p_pkg: types, character codes and the hex decoder shared by the
// ipv6 text address parser modules. no dependencies.
package ipv6p_pkg;

	localparam int NGRP = 8;
	localparam int GRP_W = 16;
	localparam int CHAR_W = 8;
	localparam int OUT_W = 136;

	localparam logic [3:0] NGRP_C = 4'd8;
	localparam logic [2:0] MAXDIG_C = 3'd4;

	localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3a;
	localparam logic [CHAR_W-1:0] CH_D0 = 8'h30;
	localparam logic [CHAR_W-1:0] CH_D9 = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LA = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LF = 8'h66;
	localparam logic [CHAR_W-1:0] CH_UA = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UF = 8'h46;

	typedef logic [GRP_W-1:0] grp_t;

	typedef struct packed {
		logic ok;
		logic gap;
		logic [3:0] gap_pos;
	} fin_t;

	// {is_hex, value}
	function automatic logic [4:0] hex_dec(input logic [CHAR_W-1:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= CH_D0 && c <= CH_D9) begin
			r = {1'b1, 4'(c - CH_D0)};
		end else if (c >= CH_LA && c <= CH_LF) begin
			r = {1'b1, 4'(c - CH_LA + 8'd10)};
		end else if (c >= CH_UA && c <= CH_UF) begin
			r = {1'b1, 4'(c - CH_UA + 8'd10)};
		end
		return r;
	endfunction

endpackage

FILE: src/ipv6p_scan.sv
`timescale 1ns / 1ps
// ipv6p_scan: per-character parse state, group collection and gap tracking.
// groups before the gap go to a front table, groups after it shift into a tail line.
// depends on ipv6p_pkg.
module ipv6p_scan
	import ipv6p_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [CHAR_W-1:0] ch,
	output fin_t              fin,
	output grp_t              front [NGRP],
	output grp_t              tail [NGRP]
);

	grp_t front_q [NGRP];
	grp_t tail_q [NGRP];
	logic [3:0] cnt_q, cnt_d;
	logic [2:0] dig_q, dig_d;
	grp_t acc_q, acc_d;
	logic [3:0] gpos_q, gpos_d;
	logic gap_q, gap_d;
	logic sep_q, sep_d;
	logic err_q, err_d;

	logic push, clr;
	logic [4:0] hx;
	logic fin_push, fin_err, fin_ok;
	logic [3:0] fin_cnt;

	assign hx = hex_dec(ch);

	always_comb begin
		cnt_d = cnt_q;
		dig_d = dig_q;
		acc_d = acc_q;
		gpos_d = gpos_q;
		gap_d = gap_q;
		sep_d = sep_q;
		err_d = err_q;
		push = 1'b0;
		clr = 1'b0;
		if (en) begin
			if (ch != CH_NUL) begin
				if (!err_q) begin
					if (hx[4]) begin
						if (dig_q >= MAXDIG_C || (sep_q && cnt_q == 4'd0 && !gap_q)) begin
							err_d = 1'b1;
						end else begin
							acc_d = {acc_q[GRP_W-5:0], hx[3:0]};
							dig_d = 3'(dig_q + 3'd1);
							sep_d = 1'b0;
						end
					end else if (ch == CH_COLON) begin
						if (dig_q != 3'd0) begin
							if (cnt_q >= NGRP_C) begin
								err_d = 1'b1;
							end else begin
								push = 1'b1;
								cnt_d = 4'(cnt_q + 4'd1);
								acc_d = '0;
								dig_d = 3'd0;
							end
							sep_d = 1'b1;
						end else if (sep_q) begin
							if (gap_q) begin
								err_d = 1'b1;
							end else begin
								gap_d = 1'b1;
								gpos_d = cnt_q;
								sep_d = 1'b0;
							end
						end else if (cnt_q == 4'd0 && !gap_q) begin
							sep_d = 1'b1;
						end else begin
							err_d = 1'b1;
						end
					end else begin
						err_d = 1'b1;
					end
				end
			end else begin
				clr = 1'b1;
				cnt_d = 4'd0;
				dig_d = 3'd0;
				acc_d = '0;
				gpos_d = 4'd0;
				gap_d = 1'b0;
				sep_d = 1'b0;
				err_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 4'd0;
			dig_q <= 3'd0;
			acc_q <= '0;
			gpos_q <= 4'd0;
			gap_q <= 1'b0;
			sep_q <= 1'b0;
			err_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			dig_q <= dig_d;
			acc_q <= acc_d;
			gpos_q <= gpos_d;
			gap_q <= gap_d;
			sep_q <= sep_d;
			err_q <= err_d;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !gap_q) begin
			front_q[cnt_q[2:0]] <= acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NGRP; i++) tail_q[i] <= '0;
		end else if (clr) begin
			for (int i = 0; i < NGRP; i++) tail_q[i] <= '0;
		end else if (push && gap_q) begin
			for (int i = 0; i < NGRP - 1; i++) tail_q[i] <= tail_q[i+1];
			tail_q[NGRP-1] <= acc_q;
		end
	end

	// closing of the open group at end of string
	assign fin_push = !err_q && dig_q != 3'd0 && cnt_q < NGRP_C;
	assign fin_err = err_q || (dig_q != 3'd0 && cnt_q >= NGRP_C) || (dig_q == 3'd0 && sep_q);
	assign fin_cnt = fin_push ? 4'(cnt_q + 4'd1) : cnt_q;
	assign fin_ok = !fin_err && (gap_q ? (fin_cnt < NGRP_C) : (fin_cnt == NGRP_C));

	assign fin.ok = fin_ok;
	assign fin.gap = gap_q;
	assign fin.gap_pos = gpos_q;

	always_comb begin
		for (int i = 0; i < NGRP; i++) begin
			front[i] = front_q[i];
			tail[i] = tail_q[i];
		end
		if (fin_push && !gap_q) begin
			front[cnt_q[2:0]] = acc_q;
		end
		if (fin_push && gap_q) begin
			for (int i = 0; i < NGRP - 1; i++) tail[i] = tail_q[i+1];
			tail[NGRP-1] = acc_q;
		end
	end

endmodule

FILE: src/ipv6p_place.sv
`timescale 1ns / 1ps
// ipv6p_place: assembles the eight address groups from the front table and
// the tail line around the gap, zero for an illegal string. depends on ipv6p_pkg.
module ipv6p_place
	import ipv6p_pkg::*;
(
	input  fin_t fin,
	input  grp_t front [NGRP],
	input  grp_t tail [NGRP],
	output grp_t grp [NGRP]
);

	always_comb begin
		for (int j = 0; j < NGRP; j++) begin
			if (!fin.ok) begin
				grp[j] = '0;
			end else if (fin.gap && 4'(j) >= fin.gap_pos) begin
				grp[j] = tail[j];
			end else begin
				grp[j] = front[j];
			end
		end
	end

endmodule

FILE: src/ipv6_text_address_parser_top.sv
`timescale 1ns / 1ps
// ipv6_text_address_parser_top: ipv6 text to binary address, one character per beat.
// result: the nul beat passes through the input register, then loads the output register.
// throughput: one character per cycle; only a nul beat waits on a full output register.
// reset: arst_n clears the parse state (not the front table) and both valid flags at once.
// depends on ipv6p_pkg, ipv6p_scan, ipv6p_place.
module ipv6_text_address_parser_top
	import ipv6p_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [CHAR_W-1:0] s_tdata,  // char_code[7:0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata   // addr_valid, group0..group7 (16 each), zero pad
);

	logic valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic adv;
	logic out_v_q;
	logic [OUT_W-1:0] out_q;
	logic [OUT_W-1:0] out_d;

	fin_t fin;
	grp_t front [NGRP];
	grp_t tail [NGRP];
	grp_t grp [NGRP];

	assign adv = valid_s1 && (char_s1 != CH_NUL || !out_v_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
		end
	end

	ipv6p_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.ch     (char_s1),
		.fin    (fin),
		.front  (front),
		.tail   (tail)
	);

	ipv6p_place u_place (
		.fin   (fin),
		.front (front),
		.tail  (tail),
		.grp   (grp)
	);

	always_comb begin
		out_d = '0;
		out_d[0] = fin.ok;
		for (int j = 0; j < NGRP; j++) begin
			out_d[1 + j*GRP_W +: GRP_W] = grp[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv && char_s1 == CH_NUL) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && char_s1 == CH_NUL) begin
			out_q <= out_d;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;

`ifndef SYNTHESIS
	a_beat_from_nul: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(adv && char_s1 == CH_NUL))
		else $error("result beat without a nul");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[OUT_W-1:1] == '0)
		else $error("illegal address carries nonzero groups");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(char_s1))
		else $error("stalled character lost");

	a_stall_only_nul: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |-> char_s1 == CH_NUL && m_tvalid)
		else $error("stall without a waiting result");
`endif

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for ipv6_text_address_parser_top, with text streamed in a
// character per beat and every result beat checked against a built-in parse model.
// depends on ipv6p_pkg and the parser rtl.
module tb;
	import ipv6p_pkg::*;

	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic [NGRP-1:0][GRP_W-1:0] grp;
		logic                       ok;
	} addr_t;

	class addr_checker;
		addr_t            want_q[$];
		logic [GRP_W-1:0] grp_store [NGRP];
		logic [3:0]       grp_cnt;
		logic [2:0]       dig_cnt;
		logic [GRP_W-1:0] grp_acc;
		logic [3:0]       gap_at;
		bit               gap_seen;
		bit               after_colon;
		bit               bad;
		int               errors;
		int               n_chars;
		int               n_addrs;
		int               n_legal;

		function new();
			errors = 0;
			n_chars = 0;
			n_addrs = 0;
			n_legal = 0;
			clear();
		endfunction

		function void clear();
			foreach (grp_store[k]) grp_store[k] = '0;
			grp_cnt = '0;
			dig_cnt = '0;
			grp_acc = '0;
			gap_at = '0;
			gap_seen = 0;
			after_colon = 0;
			bad = 0;
		endfunction

		// -1 when c is not a hex digit
		function int hex_of(logic [CHAR_W-1:0] c);
			if (c >= "0" && c <= "9") return int'(c) - int'("0");
			if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
			if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
			return -1;
		endfunction

		function void close_grp();
			if (grp_cnt >= NGRP_C) begin
				bad = 1;
				return;
			end
			grp_store[grp_cnt[2:0]] = grp_acc;
			grp_cnt = grp_cnt + 4'd1;
			grp_acc = '0;
			dig_cnt = '0;
		endfunction

		function void note_char(logic [CHAR_W-1:0] c);
			addr_t a;
			int    v;
			int    k;
			int    dst;
			bit    ok;
			n_chars++;
			if (c != CH_NUL) begin
				if (bad) return;
				v = hex_of(c);
				if (v >= 0) begin
					if (dig_cnt >= MAXDIG_C || (after_colon && grp_cnt == 0 && !gap_seen)) begin
						bad = 1;
						return;
					end
					grp_acc = {grp_acc[GRP_W-5:0], 4'(v)};
					dig_cnt = dig_cnt + 3'd1;
					after_colon = 0;
				end else if (c == CH_COLON) begin
					if (dig_cnt > 0) begin
						close_grp();
						after_colon = 1;
					end else if (after_colon) begin
						if (gap_seen) begin
							bad = 1;
						end else begin
							gap_seen = 1;
							gap_at = grp_cnt;
							after_colon = 0;
						end
					end else if (grp_cnt == 0 && !gap_seen) begin
						after_colon = 1;
					end else begin
						bad = 1;
					end
				end else begin
					bad = 1;
				end
				return;
			end
			// end of string
			if (!bad) begin
				if (dig_cnt > 0) close_grp();
				else if (after_colon) bad = 1;
			end
			ok = !bad && (gap_seen ? (grp_cnt < NGRP_C) : (grp_cnt == NGRP_C));
			a = '0;
			a.ok = ok;
			if (ok) begin
				for (k = 0; k < int'(grp_cnt); k++) begin
					dst = (gap_seen && k >= int'(gap_at)) ? k + NGRP - int'(grp_cnt) : k;
					a.grp[dst] = grp_store[k];
				end
			end
			want_q.push_back(a);
			n_addrs++;
			if (ok) n_legal++;
			clear();
		endfunction

		function void check_beat(logic [OUT_W-1:0] d);
			addr_t            w;
			logic [GRP_W-1:0] got;
			int               k;
			if (want_q.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected, expected none, actual %h",
					$time, d);
				return;
			end
			w = want_q.pop_front();
			if (d[0] !== w.ok) begin
				errors++;
				$display("%0t: addr_valid mismatch, expected %0b, actual %0b", $time, w.ok, d[0]);
			end
			for (k = 0; k < NGRP; k++) begin
				got = d[1 + GRP_W * k +: GRP_W];
				if (got !== w.grp[k]) begin
					errors++;
					$display("%0t: group%0d mismatch, expected %h, actual %h",
						$time, k, w.grp[k], got);
				end
			end
		endfunction

		function int pending();
			return want_q.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [CHAR_W-1:0] s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;

	addr_checker       sb;
	int                send_idle = 21;
	int                recv_idle = 56;
	int                stall_cnt = 0;
	logic [CHAR_W-1:0] text_q[$];

	string dir_texts[$] = '{
		"::", "0:0:0:0:0:0:0:0", "ffff:FFFF:aBcD:0:9:09af:1:fFfF", "1:2:3:4:5:6:7:8",
		"::1", "1::", "12:Ab::3:4", "1:2:3:4:5:6:7::", "::1:2:3:4:5:6:7",
		"1:2:3:4::5:6:7:8", "1:2:3:4:5:6:7", "1:2:3:4:5:6:7:8:9", "12345::", "1g::",
		":1::", ":", "1:2:3:4:5:6:7:8:", ":::", "1::2::3", "", "/@`G;::zz"
	};

	ipv6_text_address_parser_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_beat(m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cnt <= 0;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
		if (stall_cnt >= STALL_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_char(input logic [CHAR_W-1:0] c);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_char(c);
	endtask

	task automatic send_str(input string s);
		int i;
		for (i = 0; i < s.len(); i++) send_char(s[i]);
		send_char(CH_NUL);
	endtask

	task automatic send_text();
		int i;
		for (i = 0; i < text_q.size(); i++) send_char(text_q[i]);
		send_char(CH_NUL);
	endtask

	function automatic logic [CHAR_W-1:0] rand_hex();
		int v;
		v = $urandom_range(15);
		if (v < 10) return CH_D0 + CHAR_W'(v);
		return ($urandom_range(1) ? CH_UA : CH_LA) + CHAR_W'(v - 10);
	endfunction

	// mostly well-formed addresses, some broken ones, a few pure noise strings
	task automatic build_text();
		int kind;
		int n;
		int gap_slot;
		int k;
		int d;
		int pos;
		bit gap;
		text_q.delete();
		kind = $urandom_range(99);
		if (kind < 6) begin
			n = $urandom_range(12);
			repeat (n) text_q.push_back(CHAR_W'($urandom_range(1, 255)));
			return;
		end
		gap = $urandom_range(1);
		if (kind < 70) n = gap ? $urandom_range(7) : NGRP;
		else n = $urandom_range(10);
		gap_slot = $urandom_range(n);
		for (k = 0; k < n; k++) begin
			if (gap && k == gap_slot) begin
				text_q.push_back(CH_COLON);
				text_q.push_back(CH_COLON);
			end else if (k > 0) begin
				text_q.push_back(CH_COLON);
			end
			d = ($urandom_range(3) == 0) ? 4 : $urandom_range(1, 4);
			repeat (d) text_q.push_back(rand_hex());
		end
		if (gap && gap_slot == n) begin
			text_q.push_back(CH_COLON);
			text_q.push_back(CH_COLON);
		end
		if (kind >= 70) begin
			repeat ($urandom_range(0, 2)) begin
				pos = $urandom_range(text_q.size());
				case ($urandom_range(3))
					0: text_q.insert(pos, CHAR_W'($urandom_range(1, 255)));
					1: text_q.insert(pos, CH_COLON);
					2: text_q.insert(pos, rand_hex());
					default: if (pos < text_q.size()) text_q.delete(pos);
				endcase
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_texts[i]) send_str(dir_texts[i]);
		while (sb.n_chars < 420) begin
			build_text();
			send_text();
		end
		send_idle = 56;
		recv_idle = 21;
		while (sb.n_chars < 840) begin
			build_text();
			send_text();
		end
		send_idle = 0;
		recv_idle = 0;
		while (sb.n_chars < 1250) begin
			build_text();
			send_text();
		end
		s_tvalid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("streamed %0d characters forming %0d strings, %0d of them legal addresses",
			sb.n_chars, sb.n_addrs, sb.n_legal);
		$display("mismatches found: %0d", sb.errors);
		if (sb.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
